### src/gaussian_box_muller_sampler_top_macros.svh
// assertion macros for the gaussian sampler
// expects i_clk and i_rst_n in the including module
`ifndef GAUSSIAN_BOX_MULLER_SAMPLER_TOP_MACROS_SVH
`define GAUSSIAN_BOX_MULLER_SAMPLER_TOP_MACROS_SVH

// condition holds in the cycle after the trigger
`define GBMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition holds at every edge out of reset
`define GBMS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

### src/gbms_pkg.sv
// shared constants and latencies of the gaussian sampler pipeline
// no dependencies
package gbms_pkg;

    localparam int LOG_ROUNDS  = 30;
    localparam int LOG_LAT     = LOG_ROUNDS + 2;
    localparam int SQRT_STAGES = 27;
    localparam int COS_ROUNDS  = 7;
    localparam int COS_LAT     = 2 * COS_ROUNDS + 3;
    localparam int ROOT_LAT    = LOG_LAT + SQRT_STAGES;
    localparam int LAST_STAGE  = ROOT_LAT + 3;

    localparam logic [47:0] EPS_F48  = 48'd281474977;
    localparam logic [47:0] HALF_F48 = 48'h8000_0000_0000;
    localparam logic [24:0] TWO_LN2  = 25'd23258160;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

    // reciprocal multipliers for the taylor divisors 182,132,90,56,30,12,2
    localparam logic [32:0] COS_MUL [COS_ROUNDS] = '{
        33'd6041272681, 33'd8329633544, 33'd6108397933, 33'd4908534053,
        33'd4581298450, 33'd5726623062, 33'd4294967296
    };
    localparam int COS_SHIFT [COS_ROUNDS] = '{40, 40, 39, 38, 37, 36, 33};

    typedef enum logic [1:0] {
        CFG_RANDOM_MODE = 2'd0,
        CFG_MEAN_VALUE  = 2'd1,
        CFG_STD_DEV     = 2'd2
    } t_cfg_index;

endpackage

### src/gaussian_box_muller_sampler_top.sv
// gaussian sampler top: input stage, log/root and cosine paths, scaling, output
// uses gbms_pkg, gbms_log, gbms_sqrt, gbms_cos and the assertion macro header
//
// usage
// - input channel s_axis: one item carries two uniform codes (u1, u2)
// - output channel m_axis: one item carries one signed Q16.16 sample
// - configuration: i_cfg_we with i_cfg_addr 0 random mode, 1 mean, 2 sigma
//   written only while no item is in flight
// - depth: 63 register stages from input accept to output valid,
//   set by the 30 log squaring rounds and 27 square root stages in series
// - throughput: one item per cycle, a new item every clock while m_axis does not stall
// - an item with u1 below about 1e-6 in random mode gives no output item
// - reset: all valid bits clear, mode random, mean 0, sigma 1.0
// - a stall on m_axis freezes the whole pipeline; s_axis_tready drops
//   only while a finished item waits at the output
`include "gaussian_box_muller_sampler_top_macros.svh"
module gaussian_box_muller_sampler_top #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // uniform_a[31:0], uniform_b[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sample[31:0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    localparam int MASK_BITS = (UNIFORM_BITS >= 32) ? 32 : UNIFORM_BITS;
    localparam int F_SHIFT   = 48 - UNIFORM_BITS;
    localparam logic [31:0] CODE_MASK = 32'((64'd1 << MASK_BITS) - 64'd1);
    localparam int LAST      = gbms_pkg::LAST_STAGE;
    localparam int ROOT_LAT  = gbms_pkg::ROOT_LAT;
    localparam int DLY       = gbms_pkg::ROOT_LAT - gbms_pkg::COS_LAT;

    logic        r_mode;
    logic [31:0] r_mean;
    logic [30:0] r_std;
    logic        w_en;
    logic [47:0] w_fa;
    logic [47:0] w_fb;
    logic        r_vld [0:LAST];
    logic [47:0] r_fa;
    logic [47:0] r_fb;
    logic [35:0] w_x;
    logic [27:0] w_root;
    logic [30:0] w_cos_c;
    logic        w_cos_neg;
    logic [31:0] r_dc [0:DLY-1];
    logic [58:0] r_rc;
    logic        r_sa;
    logic [59:0] w_pr;
    logic [59:0] r_mp;
    logic        r_sb;
    logic [60:0] w_mr;
    logic signed [38:0] w_s;
    logic [31:0] r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_mean <= '0;
            r_std  <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gbms_pkg::CFG_RANDOM_MODE: r_mode <= i_cfg_wdata[0];
                gbms_pkg::CFG_MEAN_VALUE:  r_mean <= i_cfg_wdata;
                gbms_pkg::CFG_STD_DEV:     r_std  <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign w_en          = !r_vld[LAST] || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_fa = {16'b0, s_axis_tdata[31:0] & CODE_MASK} << F_SHIFT;
    assign w_fb = {16'b0, s_axis_tdata[63:32] & CODE_MASK} << F_SHIFT;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid && (!r_mode || w_fa >= gbms_pkg::EPS_F48);
            for (int i = 1; i <= LAST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fa <= r_mode ? w_fa : gbms_pkg::HALF_F48;
            r_fb <= r_mode ? w_fb : gbms_pkg::HALF_F48;
        end
    end

    gbms_log u_log (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_f   (r_fa),
        .o_x   (w_x)
    );

    gbms_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_x),
        .o_r   (w_root)
    );

    gbms_cos u_cos (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_f   (r_fb),
        .o_c   (w_cos_c),
        .o_neg (w_cos_neg)
    );

    // align cosine with the root
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dc[0] <= {w_cos_neg, w_cos_c};
            for (int i = 1; i < DLY; i++) begin
                r_dc[i] <= r_dc[i-1];
            end
        end
    end

    assign w_pr = {1'b0, r_rc} + 60'(1 << 29);
    assign w_mr = {1'b0, r_mp} + 61'(1 << 23);

    always_comb begin
        w_s = r_sb ? -$signed({2'b0, w_mr[60:24]}) : $signed({2'b0, w_mr[60:24]});
        w_s = w_s + 39'(signed'(r_mean));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rc <= w_root * r_dc[DLY-1][30:0];
            r_sa <= r_dc[DLY-1][31];
            r_mp <= r_std * w_pr[58:30];
            r_sb <= r_sa;
            if (w_s > 39'sd2147483647) begin
                r_out <= 32'h7FFF_FFFF;
            end else if (w_s < -39'sd2147483648) begin
                r_out <= 32'h8000_0000;
            end else begin
                r_out <= w_s[31:0];
            end
        end
    end

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = r_out;

    `GBMS_ASSERT_NEXT(a_fixed_never_rejects,
        s_axis_tvalid && s_axis_tready && !r_mode, r_vld[0], "fixed mode item dropped")
    `GBMS_ASSERT_NEXT(a_small_u1_rejected,
        s_axis_tvalid && s_axis_tready && r_mode && w_fa < gbms_pkg::EPS_F48,
        !r_vld[0], "small u1 item kept")
    `GBMS_ASSERT_ALWAYS(a_cos_bounded,
        !r_vld[gbms_pkg::COS_LAT] || w_cos_c <= gbms_pkg::ONE_Q30, "cosine above one")
    `GBMS_ASSERT_ALWAYS(a_root_bounded,
        !r_vld[ROOT_LAT] || w_root[27] == 1'b0, "root out of range")
endmodule

### src/gbms_log.sv
// -2 ln(f) in Q.30 from a 0.48 fraction: normalize, squaring rounds, scale
// uses gbms_pkg
module gbms_log (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [47:0] i_f,
    output logic [35:0] o_x
);
    localparam int NR = gbms_pkg::LOG_ROUNDS;

    logic [5:0]  n_p;
    logic [77:0] w_sh;
    logic [30:0] r_m  [0:NR];
    logic [29:0] r_fr [0:NR];
    logic [5:0]  r_p  [0:NR];
    logic [35:0] w_g;
    logic [60:0] r_prod;
    logic [61:0] w_rnd;

    always_comb begin
        n_p = '0;
        for (int i = 0; i < 48; i++) begin
            if (i_f[i]) begin
                n_p = 6'(i);
            end
        end
        w_sh = {i_f, 30'b0} >> n_p;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= w_sh[30:0];
            r_fr[0] <= '0;
            r_p[0]  <= n_p;
        end
    end

    for (genvar g = 0; g < NR; g++) begin : g_sq
        logic [61:0] w_sq;
        logic [31:0] w_mm;
        assign w_sq = r_m[g] * r_m[g];
        assign w_mm = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g+1]  <= w_mm[31] ? w_mm[31:1] : w_mm[30:0];
                r_fr[g+1] <= {r_fr[g][28:0], w_mm[31]};
                r_p[g+1]  <= r_p[g];
            end
        end
    end

    assign w_g = {6'd48 - r_p[NR], 30'b0} - {6'b0, r_fr[NR]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_g * gbms_pkg::TWO_LN2;
        end
    end

    assign w_rnd = {1'b0, r_prod} + 62'(1 << 23);
    assign o_x   = w_rnd[59:24];
endmodule

### src/gbms_sqrt.sv
// integer square root of x * 2^18, one result bit per stage
// uses gbms_pkg
module gbms_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [35:0] i_x,
    output logic [27:0] o_r
);
    localparam int NS = gbms_pkg::SQRT_STAGES;

    logic [53:0] r_v [0:NS-1];
    logic [54:0] r_r [0:NS-1];

    for (genvar g = 0; g < NS; g++) begin : g_st
        localparam logic [54:0] BIT = 55'(1) << (52 - 2 * g);
        logic [53:0] w_vi;
        logic [54:0] w_ri;
        logic [54:0] w_t;
        if (g == 0) begin : g_first
            assign w_vi = {i_x, 18'b0};
            assign w_ri = '0;
        end else begin : g_next
            assign w_vi = r_v[g-1];
            assign w_ri = r_r[g-1];
        end
        assign w_t = w_ri + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, w_vi} >= w_t) begin
                    r_v[g] <= w_vi - w_t[53:0];
                    r_r[g] <= (w_ri >> 1) + BIT;
                end else begin
                    r_v[g] <= w_vi;
                    r_r[g] <= w_ri >> 1;
                end
            end
        end
    end

    assign o_r = r_r[NS-1][27:0];
endmodule

### src/gbms_cos.sv
// |cos(2 pi u)| in Q.30 with sign: fold, angle, taylor series in horner rounds
// uses gbms_pkg
module gbms_cos (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [47:0] i_f,
    output logic [30:0] o_c,
    output logic        o_neg
);
    localparam int NR = gbms_pkg::COS_ROUNDS;

    logic [31:0] w_ph;
    logic [31:0] w_p1;
    logic        w_neg;
    logic [30:0] w_p2;
    logic [62:0] r_xp;
    logic        r_n1;
    logic [63:0] w_xr;
    logic [63:0] r_zp;
    logic        r_n2;
    logic [30:0] w_h  [0:NR];
    logic [31:0] w_z  [0:NR];
    logic        w_n  [0:NR];
    logic [62:0] r_q  [0:NR-1];
    logic [31:0] r_za [0:NR-1];
    logic        r_na [0:NR-1];
    logic [64:0] r_t  [0:NR-1];
    logic [31:0] r_zb [0:NR-1];
    logic        r_nb [0:NR-1];
    logic [30:0] r_c;
    logic        r_nc;

    assign w_ph  = i_f[47:16];
    assign w_p1  = (w_ph > 32'h8000_0000) ? 32'(33'h1_0000_0000 - {1'b0, w_ph}) : w_ph;
    assign w_neg = w_p1 > 32'h4000_0000;
    assign w_p2  = w_neg ? 31'(32'h8000_0000 - w_p1) : w_p1[30:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xp <= w_p2 * gbms_pkg::PI_Q30;
            r_n1 <= w_neg;
        end
    end

    assign w_xr = {1'b0, r_xp} + 64'(1 << 30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zp <= w_xr[62:31] * w_xr[62:31];
            r_n2 <= r_n1;
        end
    end

    assign w_h[0] = gbms_pkg::ONE_Q30;
    assign w_z[0] = r_zp[61:30];
    assign w_n[0] = r_n2;

    for (genvar g = 0; g < NR; g++) begin : g_rnd
        logic [64:0] w_tq;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]  <= w_z[g] * w_h[g];
                r_za[g] <= w_z[g];
                r_na[g] <= w_n[g];
                r_t[g]  <= r_q[g][61:30] * gbms_pkg::COS_MUL[g];
                r_zb[g] <= r_za[g];
                r_nb[g] <= r_na[g];
            end
        end
        assign w_tq     = r_t[g] >> gbms_pkg::COS_SHIFT[g];
        assign w_h[g+1] = (w_tq >= 65'(gbms_pkg::ONE_Q30)) ? '0
                          : 31'(gbms_pkg::ONE_Q30 - w_tq[30:0]);
        assign w_z[g+1] = r_zb[g];
        assign w_n[g+1] = r_nb[g];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c  <= w_h[NR];
            r_nc <= w_n[NR];
        end
    end

    assign o_c   = r_c;
    assign o_neg = r_nc;
endmodule

### test/gaussian_box_muller_sampler_top_tb.sv
// testbench for the gaussian box-muller sampler top
// predicts each sample in fixed point and checks the stream; needs gbms_pkg and the rtl
`timescale 1ns / 1ps
module gaussian_box_muller_sampler_top_tb;

    localparam int PIPE_LAT = 63;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [47:0] MIN_F48 = 48'd281474977;
    localparam logic [63:0] LN2_Q24 = 64'd11629080;
    localparam logic [63:0] PI_Q30_M = 64'd3373259426;
    localparam logic [63:0] ONE_Q30_M = 64'd1073741824;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // uniform_a[31:0], uniform_b[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // sample[31:0]
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    gaussian_box_muller_sampler_top dut (.*);

    logic               mode_q;
    logic signed [31:0] mu_q;
    logic [30:0]        sigma_q;
    logic [31:0]        sample_queue[$];
    int                 errors = 0;
    int                 items_sent = 0;
    int                 rejected = 0;
    int                 samples_seen = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    longint             cycles = 0;

    initial i_clk = 0;
    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] neg_two_ln(input logic [47:0] f);
        int p;
        logic [63:0] m, fr, g;
        p = 47;
        fr = 0;
        while (p > 0 && f[p] == 1'b0) p--;
        if (p >= 30) m = 64'(f) >> (p - 30);
        else m = 64'(f) << (30 - p);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                fr[0] = 1'b1;
            end
        end
        g = (64'(48 - p) << 30) - fr;
        return (g * 2 * LN2_Q24 + (64'd1 << 23)) >> 24;
    endfunction

    function automatic logic [63:0] cosine_mag(input logic [47:0] f, output logic neg);
        logic [63:0] ph, x, z, h, t;
        logic [63:0] divs[7];
        divs = '{182, 132, 90, 56, 30, 12, 2};
        ph = 64'(f[47:16]);
        neg = 0;
        h = ONE_Q30_M;
        if (ph > (64'd1 << 31)) ph = (64'd1 << 32) - ph;
        if (ph > ONE_Q30_M) begin
            ph = (64'd1 << 31) - ph;
            neg = 1;
        end
        x = (ph * PI_Q30_M + (64'd1 << 30)) >> 31;
        z = (x * x) >> 30;
        for (int i = 0; i < 7; i++) begin
            t = ((z * h) >> 30) / divs[i];
            h = (t >= ONE_Q30_M) ? 64'd0 : ONE_Q30_M - t;
        end
        return h;
    endfunction

    // returns 0 when the pair is rejected
    function automatic bit predict_sample(input logic [31:0] ua, input logic [31:0] ub,
                                          output logic [31:0] s);
        logic [47:0] fa, fb;
        logic [63:0] r, c, p, mag;
        logic neg;
        longint sum;
        if (mode_q) begin
            fa = {ua, 16'd0};
            fb = {ub, 16'd0};
            if (fa < MIN_F48) return 0;
        end else begin
            fa = 48'h8000_0000_0000;
            fb = 48'h8000_0000_0000;
        end
        r = isqrt(neg_two_ln(fa) << 18);
        c = cosine_mag(fb, neg);
        p = (r * c + (64'd1 << 29)) >> 30;
        mag = (64'(sigma_q) * p + (64'd1 << 23)) >> 24;
        sum = neg ? -longint'(mag) : longint'(mag);
        sum = sum + longint'(mu_q);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        s = sum[31:0];
        return 1;
    endfunction

    task automatic send_item(input logic [31:0] ua, input logic [31:0] ub);
        logic [31:0] s;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ub, ua};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (predict_sample(ua, ub, s)) sample_queue.push_back(s);
        else rejected++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input gbms_pkg::t_cfg_index idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gbms_pkg::CFG_RANDOM_MODE: mode_q = val[0];
            gbms_pkg::CFG_MEAN_VALUE:  mu_q = val;
            gbms_pkg::CFG_STD_DEV:     sigma_q = val[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_u32();
        case ($urandom_range(7))
            0: return $urandom_range(5000);
            1: return 32'hFFFF_FFFF - $urandom_range(50);
            2: return 32'h4000_0000 + $urandom_range(64) - 32;
            3: return 32'hC000_0000 + $urandom_range(64) - 32;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[8];
        edges = '{0, 1, 4294, 4295, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000};
        for (int i = 0; i < 8; i++) send_item(edges[i], edges[7 - i]);
        send_item(32'h8000_0000, 32'h4000_0001);
        send_item(32'h8000_0000, 32'h3FFF_FFFF);
        send_item(32'h0000_2000, 32'h0000_0000);
        drain();
    endtask

    task automatic test_fixed_mode();
        write_reg(gbms_pkg::CFG_RANDOM_MODE, 0);
        send_item(0, 0);
        send_item(32'hFFFF_FFFF, 32'h1234_5678);
        drain();
        write_reg(gbms_pkg::CFG_RANDOM_MODE, 1);
    endtask

    task automatic test_saturation();
        write_reg(gbms_pkg::CFG_STD_DEV, 32'h7FFF_FFFF);
        write_reg(gbms_pkg::CFG_MEAN_VALUE, 32'h7FFF_0000);
        send_item(32'd5000, 32'd0);
        send_item(32'd5000, 32'h8000_0000);
        drain();
        write_reg(gbms_pkg::CFG_MEAN_VALUE, 32'h8000_0000);
        send_item(32'd5000, 32'h8000_0000);
        send_item(32'd5000, 32'd0);
        drain();
        write_reg(gbms_pkg::CFG_STD_DEV, 0);
        send_item($urandom, $urandom);
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_reg(gbms_pkg::CFG_MEAN_VALUE,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
        write_reg(gbms_pkg::CFG_STD_DEV,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 19));
        for (int i = 0; i < n; i++) begin
            send_item(rand_u32(), rand_u32());
            if (i == n / 2) drain();
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            samples_seen++;
            if (sample_queue.size() == 0) begin
                $error("unexpected sample %h", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== sample_queue[0]) begin
                    $error("sample expected %h actual %h", sample_queue[0], m_axis_tdata);
                    errors++;
                end
                void'(sample_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 1;
        i_cfg_we = 0;
        i_cfg_addr = gbms_pkg::CFG_RANDOM_MODE;
        i_cfg_wdata = 0;
        mode_q = 1;
        mu_q = 0;
        sigma_q = 31'd65536;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fixed_mode();
        test_saturation();
        test_random(400, 0, 0);
        test_random(400, 48, 0);
        test_random(400, 0, 48);
        test_random(400, 29, 29);
        $display("sent %0d items, %0d rejected, %0d samples checked", items_sent, rejected,
                 samples_seen);
        $display("covered fixed mode, saturation, extreme sigma and mean, and flow stalls");
        if (errors == 0 && sample_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
